// ===== sv/dsgc_pkg.sv =====
// ----------------------------------------------------------------------------
// dsgc_pkg: shared types and functions for the DSATUR coloring block
// Row width, color width, register map, pending-update bundle and popcount.
// ----------------------------------------------------------------------------
package dsgc_pkg;

  localparam int MaxVerticesDefault = 64;
  localparam int RowW   = 64;
  localparam int ColorW = 6;
  localparam int CountW = 7;

  // register map: index taken from paddr[2]
  localparam logic RegVertexCount = 1'b0;
  localparam logic RegOrderMode   = 1'b1;

  localparam logic OpLoad = 1'b0;
  localparam logic OpRun  = 1'b1;

  // neighbor-color update still owed by the previous step
  typedef struct packed {
    logic              en;
    logic [5:0]        vtx;
    logic [ColorW-1:0] col;
  } pend_t;

  function automatic logic [3:0] pop8(input logic [7:0] b);
    logic [3:0] s;
    s = 4'd0;
    for (int i = 0; i < 8; i++) s = s + 4'(b[i]);
    return s;
  endfunction

  function automatic logic [CountW-1:0] pop64(input logic [RowW-1:0] x);
    logic [CountW-1:0] s;
    s = '0;
    for (int i = 0; i < 8; i++) s = s + CountW'(pop8(x[i*8 +: 8]));
    return s;
  endfunction

endpackage

// ===== sv/dsgc_eval.sv =====
// ----------------------------------------------------------------------------
// dsgc_eval: per-vertex evaluation unit
// Masks the row, folds in the owed neighbor-color update, counts bits.
// ----------------------------------------------------------------------------
module dsgc_eval (
  input  logic [dsgc_pkg::RowW-1:0]   adj,
  input  logic [dsgc_pkg::RowW-1:0]   ncs_rd,
  input  logic                        ncs_ok,
  input  logic [dsgc_pkg::RowW-1:0]   act_mask,
  input  logic [5:0]                  self_idx,
  input  dsgc_pkg::pend_t             pend,
  input  logic                        mode,
  output logic [dsgc_pkg::RowW-1:0]   eff,
  output logic [dsgc_pkg::CountW-1:0] sat,
  output logic [dsgc_pkg::CountW-1:0] deg
);

  logic [dsgc_pkg::RowW-1:0] row;
  logic [dsgc_pkg::RowW-1:0] base;

  assign row  = adj & act_mask & ~(dsgc_pkg::RowW'(1) << self_idx);
  assign base = ncs_ok ? ncs_rd : '0;
  assign eff  = (pend.en && row[pend.vtx]) ?
                (base | (dsgc_pkg::RowW'(1) << pend.col)) : base;
  assign sat  = mode ? dsgc_pkg::pop64(eff) : '0;
  assign deg  = dsgc_pkg::pop64(row);

endmodule

// ===== sv/dsatur_graph_coloring.sv =====
// ----------------------------------------------------------------------------
// dsatur_graph_coloring: DSATUR / greedy graph coloring engine
// Loads adjacency rows and ranks, colors the graph, streams one color per vertex.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one transaction per item.
//   operation=load writes neighbor_row and tie_rank for one vertex; loads at or
//   beyond MAX_VERTICES are dropped. operation=run colors vertices 0..N-1,
//   N = min(vertex_count, MAX_VERTICES).
//   A run does N steps. Each step sweeps all N vertices through a three-stage
//   evaluation pipe (memory read, saturation/degree count, compare), then
//   searches the lowest free color one byte per cycle (up to 8 bytes). The
//   sweep of the next step also applies the neighbor-color update of the
//   previous pick. Run time is set by the single shared evaluate/compare
//   unit; each emitted result passes through a read state and a send state.
//   Output channel sends N transactions in ascending vertex order; the last
//   carries last=1 and color_count. An empty run sends one transaction with
//   empty_res=1 and last=1. When the receiver stalls, hold the transaction and
//   stop; in_ready stays low until the last result is taken.
//   Reset (rst, synchronous) returns to idle, vertex_count=0, order_mode=1.
//   Per-run state is cleared at run start through valid bits, so no clearing
//   pass is needed. Config is an APB port at byte addresses 0 and 4.
// ----------------------------------------------------------------------------
module dsatur_graph_coloring #(
  parameter int MAX_VERTICES = dsgc_pkg::MaxVerticesDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        operation,
  input  logic [5:0]  vertex,
  input  logic [63:0] neighbor_row,
  input  logic [5:0]  tie_rank,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  vertex_index,
  output logic [5:0]  color,
  output logic [6:0]  color_count,
  output logic        last,
  output logic        empty_res
);

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int NW = AW + 1;
  localparam int RW = dsgc_pkg::RowW;
  localparam int CW = dsgc_pkg::ColorW;
  localparam int KW = dsgc_pkg::CountW;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SCAN  = 7'b0000010,
    S_DRAIN = 7'b0000100,
    S_PICK  = 7'b0001000,
    S_RD    = 7'b0010000,
    S_SEND  = 7'b0100000,
    S_EMPTY = 7'b1000000
  } state_t;

  state_t state;

  // configuration registers
  logic [6:0] vertex_count;
  logic       order_mode;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == dsgc_pkg::RegOrderMode) ? {31'd0, order_mode}
                                                       : {25'd0, vertex_count};

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= 7'd0;
      order_mode   <= 1'b1;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == dsgc_pkg::RegVertexCount) vertex_count <= pwdata[6:0];
      else order_mode <= pwdata[0];
    end
  end

  // memories
  logic [RW-1:0] adj_mem  [MAX_VERTICES];
  logic [5:0]    rank_mem [MAX_VERTICES];
  logic [RW-1:0] ncs_mem  [MAX_VERTICES];
  logic [CW-1:0] col_mem  [MAX_VERTICES];

  logic [RW-1:0] adj_rd, ncs_rd;
  logic [5:0]    rank_rd;
  logic [CW-1:0] col_rd;

  // run control
  logic [NW-1:0]           n_reg;
  logic [RW-1:0]           act_mask;
  logic [MAX_VERTICES-1:0] colored;
  logic [MAX_VERTICES-1:0] ncs_vld;
  logic [AW-1:0]           scan_idx;
  logic [AW-1:0]           step_cnt;
  logic [AW-1:0]           e_idx;
  logic [2:0]              chunk;
  logic [CW-1:0]           maxc;
  dsgc_pkg::pend_t         pend;

  // stage B (memory data valid)
  logic          b_vld;
  logic [AW-1:0] b_idx;
  logic          b_ok;
  logic          b_elig;
  // stage C (counts registered)
  logic          c_vld;
  logic [AW-1:0] c_idx;
  logic          c_elig;
  logic [KW-1:0] c_sat, c_deg;
  logic [5:0]    c_rank;
  logic [RW-1:0] c_ncs;
  // best so far in this step
  logic          found;
  logic [AW-1:0] bidx;
  logic [KW-1:0] bsat, bdeg;
  logic [5:0]    brank;
  logic [RW-1:0] bncs;

  logic [RW-1:0] eff;
  logic [KW-1:0] sat, deg;
  logic          better;
  logic [NW-1:0] n_clamp;
  logic [NW-1:0] n_last;
  logic [7:0]    byte_sel;
  logic [2:0]    lo;
  logic          load_ok;

  assign n_clamp = (vertex_count > 7'(MAX_VERTICES)) ? NW'(MAX_VERTICES)
                                                     : NW'(vertex_count);
  assign n_last  = n_reg - NW'(1);
  assign load_ok = {1'b0, vertex} < 7'(MAX_VERTICES);

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid && operation == dsgc_pkg::OpLoad && load_ok) begin
      adj_mem[vertex[AW-1:0]]  <= neighbor_row;
      rank_mem[vertex[AW-1:0]] <= tie_rank;
    end
    adj_rd  <= adj_mem[scan_idx];
    rank_rd <= rank_mem[scan_idx];
  end

  always_ff @(posedge clk) begin
    if (b_vld) ncs_mem[b_idx] <= eff;
    ncs_rd <= ncs_mem[scan_idx];
  end

  always_ff @(posedge clk) begin
    if (state == S_PICK && (byte_sel != 8'hFF || chunk == 3'd7))
      col_mem[bidx] <= (byte_sel != 8'hFF) ? {chunk, lo} : CW'(0);
    if (state == S_RD) col_rd <= col_mem[e_idx];
  end

  dsgc_eval u_eval (
    .adj      (adj_rd),
    .ncs_rd   (ncs_rd),
    .ncs_ok   (b_ok),
    .act_mask (act_mask),
    .self_idx (6'(b_idx)),
    .pend     (pend),
    .mode     (order_mode),
    .eff      (eff),
    .sat      (sat),
    .deg      (deg)
  );

  assign better = c_elig && (!found || c_sat > bsat ||
                  (c_sat == bsat && c_deg > bdeg) ||
                  (c_sat == bsat && c_deg == bdeg && c_rank < brank));

  // lowest clear bit inside the current byte of the picked vertex's set
  assign byte_sel = bncs[chunk*8 +: 8];
  always_comb begin
    lo = 3'd0;
    for (int i = 7; i >= 0; i--) if (!byte_sel[i]) lo = 3'(i);
  end

  // evaluation pipe
  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
      c_vld <= 1'b0;
    end else begin
      b_vld <= (state == S_SCAN);
      c_vld <= b_vld;
    end
    b_idx  <= scan_idx;
    b_ok   <= ncs_vld[scan_idx];
    b_elig <= !colored[scan_idx];
    c_idx  <= b_idx;
    c_elig <= b_elig;
    c_sat  <= sat;
    c_deg  <= deg;
    c_rank <= rank_rd;
    c_ncs  <= eff;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      n_reg    <= '0;
      colored  <= '0;
      ncs_vld  <= '0;
      scan_idx <= '0;
      step_cnt <= '0;
      e_idx    <= '0;
      chunk    <= '0;
      maxc     <= '0;
      pend     <= '0;
      found    <= 1'b0;
    end else begin
      if (b_vld) ncs_vld[b_idx] <= 1'b1;
      if (c_vld && better) begin
        found <= 1'b1;
        bidx  <= c_idx;
        bsat  <= c_sat;
        bdeg  <= c_deg;
        brank <= c_rank;
        bncs  <= c_ncs;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid && operation == dsgc_pkg::OpRun) begin
            n_reg    <= n_clamp;
            e_idx    <= '0;
            colored  <= '0;
            ncs_vld  <= '0;
            pend     <= '0;
            step_cnt <= '0;
            scan_idx <= '0;
            maxc     <= '0;
            found    <= 1'b0;
            for (int j = 0; j < RW; j++) act_mask[j] <= (j < int'(n_clamp));
            state    <= (n_clamp == '0) ? S_EMPTY : S_SCAN;
          end
        end
        S_SCAN: begin
          // issue one vertex per cycle
          if ({1'b0, scan_idx} == n_last) state <= S_DRAIN;
          else scan_idx <= scan_idx + AW'(1);
        end
        S_DRAIN: begin
          if (!b_vld && !c_vld) begin
            chunk <= '0;
            state <= S_PICK;
          end
        end
        S_PICK: begin
          if (byte_sel != 8'hFF || chunk == 3'd7) begin
            logic [CW-1:0] c;
            c = (byte_sel != 8'hFF) ? {chunk, lo} : CW'(0);
            colored[bidx] <= 1'b1;
            if (c > maxc) maxc <= c;
            pend.en  <= 1'b1;
            pend.vtx <= 6'(bidx);
            pend.col <= c;
            found    <= 1'b0;
            scan_idx <= '0;
            if ({1'b0, step_cnt} == n_last) begin
              state <= S_RD;
            end else begin
              step_cnt <= step_cnt + AW'(1);
              state    <= S_SCAN;
            end
          end else begin
            chunk <= chunk + 3'd1;
          end
        end
        S_RD: state <= S_SEND;
        S_SEND: begin
          if (out_ready) begin
            if ({1'b0, e_idx} == n_last) begin
              state <= S_IDLE;
            end else begin
              e_idx <= e_idx + AW'(1);
              state <= S_RD;
            end
          end
        end
        S_EMPTY: if (out_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // output transaction, held from registers while stalled
  assign in_ready     = (state == S_IDLE);
  assign out_valid    = (state == S_SEND) || (state == S_EMPTY);
  assign empty_res    = (state == S_EMPTY);
  assign last         = (state == S_EMPTY) || ({1'b0, e_idx} == n_last);
  assign vertex_index = (state == S_EMPTY) ? 6'd0 : 6'(e_idx);
  assign color        = (state == S_EMPTY) ? 6'd0 : col_rd;
  assign color_count  = (state == S_SEND && {1'b0, e_idx} == n_last) ?
                        (7'(maxc) + 7'd1) : 7'd0;

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: graph coloring engine check
// Loads adjacency rows and ranks, runs DSATUR and greedy colorings under
// random input gaps and output stalls, and checks every reported color
// against a behavioral coloring computed inside the testbench.
// ----------------------------------------------------------------------------
module testbench;

  typedef enum logic [1:0] {StLoad, StRun, StCfg} stim_kind_t;

  typedef struct packed {
    logic [5:0] vidx;
    logic [5:0] col;
    logic [6:0] cnt;
    logic       lst;
    logic       emp;
  } color_report_t;

  typedef struct packed {
    stim_kind_t    kind;
    logic [5:0]    vtx;
    logic [63:0]   nbr;
    logic [5:0]    rank;
    logic          reg_idx;
    logic [31:0]   value;
    logic          typed;
    color_report_t want;
  } stim_row_t;

  localparam int NumDirected = 21;
  localparam int RandomItems = 140;
  localparam int SettleCycles = 20;
  localparam int Uncolored = 64;

  logic        clk, rst;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;
  logic        in_valid, in_ready;
  logic        operation;
  logic [5:0]  vertex;
  logic [63:0] neighbor_row;
  logic [5:0]  tie_rank;
  logic        out_valid, out_ready;
  logic [5:0]  vertex_index, color;
  logic [6:0]  color_count;
  logic        last, empty_res;

  // shadow of the block: loaded graph and configuration
  logic [63:0] shadow_rows [64];
  logic [5:0]  shadow_ranks [64];
  logic [63:0] rows_written;
  logic [6:0]  shadow_count;
  logic        shadow_mode;

  color_report_t color_reports_due [$];
  stim_row_t     directed [NumDirected];
  int            mismatches;
  int            items_sent;
  bit            calm;

  dsatur_graph_coloring dut (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid, .in_ready, .operation, .vertex, .neighbor_row, .tie_rank,
    .out_valid, .out_ready, .vertex_index, .color, .color_count, .last,
    .empty_res
  );

  always begin
    clk = 1'b1; #2;
    clk = 1'b0; #2;
  end

  initial begin
    #2000000;
    $display("testbench: done, errors");
    $finish;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // Color the shadow graph exactly as the block should and queue the reports.
  task automatic predict_coloring();
    int            n, best, best_sat, best_deg, best_rank, sat, deg, c, max_color;
    logic [63:0]   active;
    logic [63:0]   row [64];
    logic [63:0]   nb_colors [64];
    int            vcolor [64];
    color_report_t r;
    n = (shadow_count > 64) ? 64 : int'(shadow_count);
    if (n == 0) begin
      r = '{vidx: 0, col: 0, cnt: 0, lst: 1'b1, emp: 1'b1};
      color_reports_due.push_back(r);
      return;
    end
    active = (n == 64) ? '1 : ((64'd1 << n) - 64'd1);
    for (int v = 0; v < 64; v++) begin
      row[v] = shadow_rows[v] & active & ~(64'd1 << v);
      nb_colors[v] = '0;
      vcolor[v] = Uncolored;
    end
    for (int k = 0; k < n; k++) begin
      best = n; best_sat = 0; best_deg = 0; best_rank = 0;
      for (int v = 0; v < n; v++) begin
        if (vcolor[v] != Uncolored) continue;
        sat = shadow_mode ? $countones(nb_colors[v]) : 0;
        deg = $countones(row[v]);
        if (best == n || sat > best_sat || (sat == best_sat && deg > best_deg) ||
            (sat == best_sat && deg == best_deg && shadow_ranks[v] < best_rank)) begin
          best = v; best_sat = sat; best_deg = deg; best_rank = shadow_ranks[v];
        end
      end
      c = 0;
      while (c < 64 && nb_colors[best][c]) c++;
      vcolor[best] = c & 63;
      for (int u = 0; u < n; u++)
        if (row[u][best]) nb_colors[u][c & 63] = 1'b1;
    end
    max_color = 0;
    for (int v = 0; v < n; v++)
      if (vcolor[v] > max_color) max_color = vcolor[v];
    for (int v = 0; v < n; v++) begin
      r.vidx = v[5:0];
      r.col  = vcolor[v][5:0];
      r.cnt  = (v == n - 1) ? 7'(max_color + 1) : 7'd0;
      r.lst  = (v == n - 1);
      r.emp  = 1'b0;
      color_reports_due.push_back(r);
    end
  endtask

  // Compare one accepted output transaction with the oldest expectation.
  task automatic check_report();
    color_report_t want;
    if (color_reports_due.size() == 0) begin
      report_mismatch("unexpected result, vertex_index", vertex_index, -1);
      return;
    end
    want = color_reports_due.pop_front();
    if (vertex_index !== want.vidx) report_mismatch("vertex_index", vertex_index, want.vidx);
    if (color !== want.col)         report_mismatch("color", color, want.col);
    if (color_count !== want.cnt)   report_mismatch("color_count", color_count, want.cnt);
    if (last !== want.lst)          report_mismatch("last", last, want.lst);
    if (empty_res !== want.emp)     report_mismatch("empty_res", empty_res, want.emp);
  endtask

  // Receiver: check at the edge, then pick the stall for the next cycle.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) check_report();
      out_ready <= calm || ($urandom_range(99) >= 32);
    end
  end

  function automatic logic [63:0] random_row();
    logic [63:0] a;
    a = {$urandom, $urandom};
    case ($urandom_range(4))
      0: return a;
      1: return a & {$urandom, $urandom} & {$urandom, $urandom};
      2: return '1;
      3: return '0;
      default: return a & {$urandom, $urandom};
    endcase
  endfunction

  // Predict, then present one input transaction and hold it until accepted.
  task automatic send_item(input logic op, input logic [5:0] v, input logic [63:0] nbr,
                           input logic [5:0] rank, input bit typed, input color_report_t want);
    if (op == dsgc_pkg::OpLoad) begin
      shadow_rows[v] = nbr;
      shadow_ranks[v] = rank;
      rows_written[v] = 1'b1;
    end else if (typed) begin
      color_reports_due.push_back(want);
    end else begin
      predict_coloring();
    end
    if (!calm && $urandom_range(99) < 32) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    operation    <= op;
    vertex       <= v;
    neighbor_row <= nbr;
    tie_rank     <= rank;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // Drop valid and wait until every expected result has come, plus a margin
  // for a trailing load that produces no result.
  task automatic settle();
    in_valid <= 1'b0;
    while (color_reports_due.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic apb_write(input logic idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (idx == dsgc_pkg::RegVertexCount) shadow_count = value[6:0];
    else shadow_mode = value[0];
    @(posedge clk);
  endtask

  function automatic stim_row_t row_load(input logic [5:0] v, input logic [63:0] nbr,
                                         input logic [5:0] rank);
    return '{kind: StLoad, vtx: v, nbr: nbr, rank: rank, reg_idx: 0, value: 0,
             typed: 0, want: '0};
  endfunction

  function automatic stim_row_t row_run(input bit empty);
    stim_row_t s;
    s = '{kind: StRun, vtx: 0, nbr: 0, rank: 0, reg_idx: 0, value: 0,
          typed: empty, want: '0};
    // empty graph: one result with last and empty_res set, all else zero
    if (empty) s.want = '{vidx: 0, col: 0, cnt: 0, lst: 1'b1, emp: 1'b1};
    return s;
  endfunction

  function automatic stim_row_t row_cfg(input logic idx, input logic [31:0] value);
    return '{kind: StCfg, vtx: 0, nbr: 0, rank: 0, reg_idx: idx, value: value,
             typed: 0, want: '0};
  endfunction

  initial begin
    int          phase, req, eff, runs;
    logic [63:0] r;
    rst = 1'b1;
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0; paddr <= '0; pwdata <= '0;
    in_valid <= 1'b0; operation <= dsgc_pkg::OpLoad; vertex <= '0; neighbor_row <= '0;
    tie_rank <= '0;
    mismatches = 0; items_sent = 0; calm = 0;
    rows_written = '0; shadow_count = '0; shadow_mode = 1'b1;
    for (int v = 0; v < 64; v++) begin
      shadow_rows[v] = '0;
      shadow_ranks[v] = '0;
    end

    // run after reset is empty; small graphs cover self bits, bits beyond the
    // active count, asymmetric rows, rank ties, both order modes and vertex 63
    directed[0]  = row_run(1);
    directed[1]  = row_cfg(dsgc_pkg::RegOrderMode, 32'd1);
    directed[2]  = row_cfg(dsgc_pkg::RegVertexCount, 32'd3);
    directed[3]  = row_load(6'd0, '1, 6'd63);
    directed[4]  = row_load(6'd1, 64'd0, 6'd0);
    directed[5]  = row_load(6'd2, 64'h5, 6'd5);
    directed[6]  = row_run(0);
    directed[7]  = row_cfg(dsgc_pkg::RegOrderMode, 32'd0);
    directed[8]  = row_run(0);
    directed[9]  = row_load(6'd63, '1, 6'd63);
    directed[10] = row_load(6'd3, 64'h1, 6'd0);
    directed[11] = row_load(6'd4, 64'h8000_0000_0000_0008, 6'd0);
    directed[12] = row_cfg(dsgc_pkg::RegVertexCount, 32'd5);
    directed[13] = row_run(0);
    directed[14] = row_cfg(dsgc_pkg::RegOrderMode, 32'hffff_ffff);
    directed[15] = row_run(0);
    directed[16] = row_cfg(dsgc_pkg::RegVertexCount, 32'hffff_ff00);
    directed[17] = row_run(1);
    directed[18] = row_load(6'd63, 64'd0, 6'd0);
    directed[19] = row_cfg(dsgc_pkg::RegVertexCount, 32'd2);
    directed[20] = row_run(0);

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) begin
      case (directed[i].kind)
        StCfg: begin
          settle();
          apb_write(directed[i].reg_idx, directed[i].value);
        end
        StLoad: send_item(dsgc_pkg::OpLoad, directed[i].vtx, directed[i].nbr,
                          directed[i].rank, 1'b0, '0);
        default: send_item(dsgc_pkg::OpRun, '0, '0, '0, directed[i].typed,
                           directed[i].want);
      endcase
    end

    // Random phases: configure while idle, load the active rows, run.
    // Phase 0 uses the full graph, phase 1 a count above the maximum,
    // phases 3 to 5 run with no gaps or stalls on either side.
    phase = 0;
    while (items_sent < RandomItems || phase < 6) begin
      settle();
      calm = (phase >= 3 && phase < 6);
      case (phase)
        0: req = 64;
        1: req = $urandom_range(65, 127);
        2: req = 0;
        default: begin
          case ($urandom_range(19))
            0: req = $urandom_range(25, 127);
            1: req = 0;
            2, 3, 4: req = $urandom_range(9, 24);
            default: req = $urandom_range(1, 8);
          endcase
        end
      endcase
      apb_write(dsgc_pkg::RegVertexCount, {$urandom} & 32'hffff_ff80 | 32'(req));
      apb_write(dsgc_pkg::RegOrderMode, $urandom);
      eff = (req > 64) ? 64 : req;
      for (int v = 0; v < eff; v++)
        if (!rows_written[v] || $urandom_range(2) == 0)
          send_item(dsgc_pkg::OpLoad, v[5:0], random_row(), 6'($urandom), 1'b0, '0);
      // noise: stray loads anywhere in the table, inside or outside the graph
      repeat ($urandom_range(2)) begin
        r = random_row();
        send_item(dsgc_pkg::OpLoad, 6'($urandom), r, 6'($urandom), 1'b0, '0);
      end
      runs = ($urandom_range(3) == 0) ? 2 : 1;
      repeat (runs) send_item(dsgc_pkg::OpRun, '0, '0, '0, 1'b0, '0);
      phase++;
    end

    settle();
    if (mismatches == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
